### rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL; every check is sampled on clk and
// held off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define IMUOC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("imuoc check failed");

// Next-cycle implication.
`define IMUOC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("imuoc check failed");

`endif

### rtl/core/imuoc_pkg.sv
`default_nettype none

package imuoc_pkg;

  localparam int SAMPLE_W = 16;
  localparam int SUM_W    = 32;
  localparam int DB_W     = 15;
  localparam int LANES    = 6;
  localparam int LANE_GYRO0 = 3;
  localparam int CNT_W    = 5;

  // operation codes carried in in_tuser
  localparam logic [1:0] OP_NORMAL   = 2'd0;
  localparam logic [1:0] OP_GYRO_CAL = 2'd1;
  localparam logic [1:0] OP_ACC_CAL  = 2'd2;
  localparam logic [1:0] OP_RSVD     = 2'd3;

  // configuration register indexes
  localparam logic CFG_SAMPLE_COUNT  = 1'b0;
  localparam logic CFG_GYRO_DEADBAND = 1'b1;

  localparam logic [SAMPLE_W-1:0] SAMPLE_COUNT_RST = 16'd1000;
  localparam logic [DB_W-1:0]     DEADBAND_RST     = 15'd3;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

`default_nettype wire

### rtl/core/imuoc_serial_add.sv
`default_nettype none

// One bit per cycle while en is high, add or subtract; LSB first, carry kept between bits.
module imuoc_serial_add (
  input  wire logic clk,
  input  wire logic en,
  input  wire logic first,
  input  wire logic sub,
  input  wire logic a,
  input  wire logic b,
  output logic      s
);
  logic carry_r;
  logic cin;
  logic bb;
  logic cout;

  assign bb   = b ^ sub;
  assign cin  = first ? sub : carry_r;
  assign s    = a ^ bb ^ cin;
  assign cout = (a & bb) | (a & cin) | (bb & cin);

  always_ff @(posedge clk) begin
    if (en) begin
      carry_r <= cout;
    end
  end

endmodule

`default_nettype wire

### rtl/core/imuoc_divider.sv
`default_nettype none

// Signed 32 / unsigned 16 restoring divider, one quotient bit per cycle.
// Quotient truncates toward zero; only its low 16 bits are returned.
module imuoc_divider (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [imuoc_pkg::SUM_W-1:0]    dividend,
  input  wire logic [imuoc_pkg::SAMPLE_W-1:0] divisor,
  output imuoc_pkg::div_status_t         status,
  output logic [imuoc_pkg::SAMPLE_W-1:0] quotient
);
  import imuoc_pkg::*;

  logic                busy_r;
  logic                done_r;
  logic                neg_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [SAMPLE_W-1:0] rem_r;
  logic [SUM_W-1:0]    quo_r;

  logic [SAMPLE_W:0]   trial;
  logic [SAMPLE_W:0]   trial_sub;
  logic                fits;
  logic [SAMPLE_W-1:0] rem_nxt;

  assign trial     = {rem_r, quo_r[SUM_W-1]};
  assign trial_sub = trial - {1'b0, divisor};
  assign fits      = (trial >= {1'b0, divisor});
  assign rem_nxt   = fits ? trial_sub[SAMPLE_W-1:0] : trial[SAMPLE_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(SUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[SUM_W-1];
      quo_r <= dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= {quo_r[SUM_W-2:0], fits};
      rem_r <= rem_nxt;
    end
  end

  assign status.busy = busy_r;
  assign status.done = done_r;
  assign quotient    = neg_r ? (~quo_r[SAMPLE_W-1:0] + 1'b1) : quo_r[SAMPLE_W-1:0];

endmodule

`default_nettype wire

### rtl/core/imu_offset_calibrate_and_correct.sv
// Flow: a normal frame runs the 16-bit correction and is then emitted; a calibration frame
// runs the 32-bit sum update and the sample count check, and the frame that ends a calibration
// also runs three divisions before it is emitted; operation 3 is emitted unchanged.
// A new frame is taken only once the last one has been emitted; the work is done by the bit-serial
// adders (16 bits for correction, 32 for the sums) and the shared divider (three divisions at calibration end).
// Reset (rst_n low, synchronous): sums, frame counters and offsets clear to zero,
// sample_count returns to 1000 and gyro_deadband to 3; no clearing pass.
`default_nettype none

`include "assert_macros.svh"

module imu_offset_calibrate_and_correct (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // acc_x_raw, acc_y_raw, acc_z_raw, gyro_x_raw, gyro_y_raw, gyro_z_raw
  input  wire logic [95:0] in_tdata,
  // operation
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // acc_x_out, acc_y_out, acc_z_out, gyro_x_out, gyro_y_out, gyro_z_out
  output logic [95:0]      out_tdata,
  // calibration_done
  output logic             out_tuser,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_wdata
);
  import imuoc_pkg::*;

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_RUN       = 3'd1;
  localparam logic [2:0] ST_COUNT     = 3'd2;
  localparam logic [2:0] ST_DIV_START = 3'd3;
  localparam logic [2:0] ST_DIV_WAIT  = 3'd4;
  localparam logic [2:0] ST_EMIT      = 3'd5;

  function automatic logic [SAMPLE_W-1:0] deadband(input logic [SAMPLE_W-1:0] v,
                                                   input logic [DB_W-1:0] db);
    logic signed [SAMPLE_W:0] vs;
    logic signed [SAMPLE_W:0] dbs;
    vs  = {v[SAMPLE_W-1], v};
    dbs = {2'b00, db};
    if ((vs > -dbs) && (vs < dbs)) begin
      return '0;
    end
    return v;
  endfunction

  logic [2:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [1:0]          div_lane_r, div_lane_nxt;
  logic [1:0]          op_r;
  logic                done_r;
  logic [SAMPLE_W-1:0] sample_count_r;
  logic [DB_W-1:0]     deadband_r;
  logic [SAMPLE_W-1:0] gyro_seen_r;
  logic [SAMPLE_W-1:0] acc_seen_r;
  logic [SAMPLE_W-1:0] div_cnt_r;

  logic [SAMPLE_W-1:0] smp_r [LANES];
  logic [SAMPLE_W-1:0] off_r [LANES];
  logic [SAMPLE_W-1:0] res_r [LANES];
  logic [SUM_W-1:0]    sum_r [LANES];

  logic                out_valid_r;
  logic [95:0]         out_data_r;
  logic                out_user_r;

  logic                in_fire;
  logic                emit_go;
  logic                op_norm;
  logic                op_cal;
  logic [LANES-1:0]    s_bit;
  logic [95:0]         frame_out;

  logic [SAMPLE_W-1:0] seen_cur;
  logic [SAMPLE_W-1:0] seen_inc;
  logic [SAMPLE_W-1:0] count_eff;
  logic                cal_done;

  logic [2:0]          lane_idx;
  logic                div_wr;
  div_status_t         div_stat;
  logic [SAMPLE_W-1:0] div_q;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid & in_tready;
  assign emit_go   = (state_r == ST_EMIT) && (!out_valid_r || out_tready);
  assign op_norm   = (op_r == OP_NORMAL);
  assign op_cal    = (op_r == OP_GYRO_CAL) || (op_r == OP_ACC_CAL);

  assign seen_cur  = (op_r == OP_GYRO_CAL) ? gyro_seen_r : acc_seen_r;
  assign seen_inc  = seen_cur + 1'b1;
  assign count_eff = (sample_count_r == '0) ? SAMPLE_W'(1) : sample_count_r;
  assign cal_done  = (seen_inc == '0) || (seen_inc >= count_eff);

  assign lane_idx  = ((op_r == OP_GYRO_CAL) ? 3'(LANE_GYRO0) : 3'd0) + {1'b0, div_lane_r};
  assign div_wr    = (state_r == ST_DIV_WAIT) && div_stat.done;

  // per-axis lanes: bit-serial correction or sum update
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    localparam bit IS_GYRO = (g >= LANE_GYRO0);
    logic cal_sel;
    logic a_bit;
    logic b_bit;

    assign cal_sel = IS_GYRO ? (op_r == OP_GYRO_CAL) : (op_r == OP_ACC_CAL);
    assign a_bit   = op_norm ? smp_r[g][0] : sum_r[g][0];
    // past bit 15 the raw sample is sign extended into the 32-bit sum
    assign b_bit   = op_norm ? off_r[g][0]
                             : (cnt_r[CNT_W-1] ? smp_r[g][SAMPLE_W-1] : smp_r[g][0]);

    imuoc_serial_add u_add (
      .clk   (clk),
      .en    (state_r == ST_RUN),
      .first (cnt_r == '0),
      .sub   (op_norm),
      .a     (a_bit),
      .b     (b_bit),
      .s     (s_bit[g])
    );

    always_ff @(posedge clk) begin
      if (in_fire) begin
        smp_r[g] <= in_tdata[g*SAMPLE_W +: SAMPLE_W];
      end else if ((state_r == ST_RUN) && !cnt_r[CNT_W-1]) begin
        // rotate, so the raw sample is back in place after 16 bits
        smp_r[g] <= {smp_r[g][0], smp_r[g][SAMPLE_W-1:1]};
      end
      if ((state_r == ST_RUN) && op_norm) begin
        res_r[g] <= {s_bit[g], res_r[g][SAMPLE_W-1:1]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        off_r[g] <= '0;
        sum_r[g] <= '0;
      end else begin
        if ((state_r == ST_RUN) && op_norm) begin
          off_r[g] <= {off_r[g][0], off_r[g][SAMPLE_W-1:1]};
        end else if (div_wr && (lane_idx == 3'(g))) begin
          off_r[g] <= div_q;
        end
        if ((state_r == ST_RUN) && op_cal && cal_sel) begin
          sum_r[g] <= {s_bit[g], sum_r[g][SUM_W-1:1]};
        end else if (div_wr && (lane_idx == 3'(g))) begin
          sum_r[g] <= '0;
        end
      end
    end

    if ((g < LANE_GYRO0) && (g != LANE_GYRO0 - 1)) begin : g_acc_corr
      assign frame_out[g*SAMPLE_W +: SAMPLE_W] = op_norm ? res_r[g] : smp_r[g];
    end else if (g < LANE_GYRO0) begin : g_acc_z
      assign frame_out[g*SAMPLE_W +: SAMPLE_W] = smp_r[g];
    end else begin : g_gyro
      assign frame_out[g*SAMPLE_W +: SAMPLE_W] =
        op_norm ? deadband(res_r[g], deadband_r) : smp_r[g];
    end
  end

  imuoc_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == ST_DIV_START),
    .dividend (sum_r[lane_idx]),
    .divisor  (div_cnt_r),
    .status   (div_stat),
    .quotient (div_q)
  );

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    div_lane_nxt = div_lane_r;
    unique case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (in_fire) begin
          state_nxt = (in_tuser == OP_RSVD) ? ST_EMIT : ST_RUN;
        end
      end
      ST_RUN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (op_norm && (cnt_r == CNT_W'(SAMPLE_W - 1))) begin
          state_nxt = ST_EMIT;
        end else if (cnt_r == CNT_W'(SUM_W - 1)) begin
          state_nxt = ST_COUNT;
        end
      end
      ST_COUNT: begin
        div_lane_nxt = '0;
        state_nxt    = cal_done ? ST_DIV_START : ST_EMIT;
      end
      ST_DIV_START: begin
        state_nxt = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_stat.done) begin
          if (div_lane_r == 2'd2) begin
            state_nxt = ST_EMIT;
          end else begin
            div_lane_nxt = div_lane_r + 1'b1;
            state_nxt    = ST_DIV_START;
          end
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      cnt_r          <= '0;
      div_lane_r     <= '0;
      done_r         <= 1'b0;
      sample_count_r <= SAMPLE_COUNT_RST;
      deadband_r     <= DEADBAND_RST;
      gyro_seen_r    <= '0;
      acc_seen_r     <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      div_lane_r <= div_lane_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SAMPLE_COUNT:  sample_count_r <= cfg_wdata;
          CFG_GYRO_DEADBAND: deadband_r     <= cfg_wdata[DB_W-1:0];
          default:           ;
        endcase
      end
      if (in_fire) begin
        done_r <= 1'b0;
      end else if (state_r == ST_COUNT) begin
        done_r <= cal_done;
        if (op_r == OP_GYRO_CAL) begin
          gyro_seen_r <= cal_done ? '0 : seen_inc;
        end else begin
          acc_seen_r <= cal_done ? '0 : seen_inc;
        end
      end
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r <= in_tuser;
    end
    if (state_r == ST_COUNT) begin
      div_cnt_r <= count_eff;
    end
    if (emit_go) begin
      out_data_r <= frame_out;
      out_user_r <= done_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  `IMUOC_ASSERT_IMP(a_done_only_cal, (state_r == ST_EMIT) && done_r,
                    (op_r == OP_GYRO_CAL) || (op_r == OP_ACC_CAL))
  `IMUOC_ASSERT_IMP(a_div_done_in_wait, div_stat.done, state_r == ST_DIV_WAIT)
  `IMUOC_ASSERT_IMP(a_seen_cleared, (state_r == ST_EMIT) && done_r,
                    ((op_r == OP_GYRO_CAL) && (gyro_seen_r == '0)) ||
                    ((op_r == OP_ACC_CAL) && (acc_seen_r == '0)))
  `IMUOC_ASSERT_NXT(a_last_div_emits,
                    (state_r == ST_DIV_WAIT) && div_stat.done && (div_lane_r == 2'd2),
                    (state_r == ST_EMIT) && done_r)

endmodule

`default_nettype wire

### test/imu_offset_calibrate_and_correct_tb.sv
`default_nettype none

module imu_offset_calibrate_and_correct_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import imuoc_pkg::*;

  localparam int TOTAL_FRAMES   = 900;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 300;
  localparam int DRAIN_CYCLES   = 150;
  localparam int SENS_GYRO      = 0;
  localparam int SENS_ACC       = 1;

  // smp[0] is acc_x, smp[5] is gyro_z, same order as tdata
  typedef struct packed {
    logic [1:0]       op;
    logic [5:0][15:0] smp;
  } imu_frame_t;

  typedef struct packed {
    logic             done;
    logic [5:0][15:0] smp;
  } imu_result_t;

  typedef enum int {ROW_FRAME, ROW_CHECKED, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e kind;
    int        op;                              // register index on ROW_CFG rows
    int        ax, ay, az, gx, gy, gz;          // ax holds the value on ROW_CFG rows
    int        wax, way, waz, wgx, wgy, wgz, wdone;
  } dir_row_t;

  localparam dir_row_t DIR_TAB [28] = '{
    '{ROW_CHECKED, OP_NORMAL, 32767, -32768, 0, 2, -2, 3,
      32767, -32768, 0, 0, 0, 3, 0},
    '{ROW_CHECKED, OP_NORMAL, -1, 1, 12345, -3, 32767, -32768,
      -1, 1, 12345, -3, 32767, -32768, 0},
    '{ROW_CHECKED, OP_RSVD, -32768, 32767, 1, 1, -1, 0,
      -32768, 32767, 1, 1, -1, 0, 0},
    // a count of zero acts as one
    '{ROW_CFG, CFG_SAMPLE_COUNT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_CHECKED, OP_GYRO_CAL, 11, 22, 33, 100, -100, 32767,
      11, 22, 33, 100, -100, 32767, 1},
    '{ROW_FRAME, OP_NORMAL, 5, 6, 7, 101, -100, -32768, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_CFG, CFG_SAMPLE_COUNT, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_CHECKED, OP_ACC_CAL, -32768, 32767, 500, 7, 8, 9,
      -32768, 32767, 500, 7, 8, 9, 1},
    '{ROW_FRAME, OP_NORMAL, 0, -1, -32768, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_CFG, CFG_GYRO_DEADBAND, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_FRAME, OP_NORMAL, 0, 0, 0, 101, -99, -1, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_CFG, CFG_GYRO_DEADBAND, 32767, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_FRAME, OP_NORMAL, 1, 2, 3, -32768, 32767, 100, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_FRAME, OP_NORMAL, 4, 5, 6, 99, -101, 32766, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_CFG, CFG_SAMPLE_COUNT, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_CFG, CFG_GYRO_DEADBAND, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    // gyro and accel calibrations interleaved, with a normal frame between
    '{ROW_CHECKED, OP_GYRO_CAL, 1, 1, 1, -1, -32768, 32767,
      1, 1, 1, -1, -32768, 32767, 0},
    '{ROW_CHECKED, OP_ACC_CAL, -9, 9, 0, 0, 0, 0, -9, 9, 0, 0, 0, 0, 0},
    '{ROW_FRAME, OP_NORMAL, 10, 10, 10, 5, 5, 5, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_CHECKED, OP_GYRO_CAL, 2, 2, 2, -3, -32768, 32767,
      2, 2, 2, -3, -32768, 32767, 0},
    '{ROW_CHECKED, OP_GYRO_CAL, 3, 3, 3, -3, -32768, 32767,
      3, 3, 3, -3, -32768, 32767, 1},
    '{ROW_FRAME, OP_NORMAL, 0, 0, 0, -4, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    // raise the count, then lower it while an accel calibration is under way
    '{ROW_CFG, CFG_SAMPLE_COUNT, 65535, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_CHECKED, OP_ACC_CAL, -9, 9, 1, 0, 0, 0, -9, 9, 1, 0, 0, 0, 0},
    '{ROW_CHECKED, OP_ACC_CAL, -9, 9, 2, 0, 0, 0, -9, 9, 2, 0, 0, 0, 0},
    '{ROW_CFG, CFG_SAMPLE_COUNT, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_CHECKED, OP_ACC_CAL, -9, 9, 3, 0, 0, 0, -9, 9, 3, 0, 0, 0, 1},
    '{ROW_FRAME, OP_NORMAL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;      // acc_x, acc_y, acc_z, gyro_x, gyro_y, gyro_z
  logic [1:0]  in_tuser = OP_NORMAL; // operation
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;          // acc_x, acc_y, acc_z, gyro_x, gyro_y, gyro_z
  logic        out_tuser;          // calibration_done
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_SAMPLE_COUNT;
  logic [15:0] cfg_wdata = '0;

  imu_offset_calibrate_and_correct dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state: index 0 gyro, 1 accel
  logic [15:0] sample_cnt = SAMPLE_COUNT_RST;
  int          gyro_db = int'(DEADBAND_RST);
  int          cal_sum  [2][3];
  logic [15:0] cal_seen [2];
  logic [15:0] cal_off  [2][3];

  imu_result_t results_due [$];
  int          frames_in = 0;
  int          frames_out = 0;
  int          mismatches = 0;
  int          burst_left = 0;
  int          hold_req = 0;
  int          hold_served = 0;
  string       lane_label [6] = '{"acc_x_out", "acc_y_out", "acc_z_out",
                                  "gyro_x_out", "gyro_y_out", "gyro_z_out"};

  initial begin
    for (int s = 0; s < 2; s++) begin
      cal_seen[s] = '0;
      for (int i = 0; i < 3; i++) begin
        cal_sum[s][i] = 0;
        cal_off[s][i] = '0;
      end
    end
  end

  function automatic bit accumulate_cal(int s, logic [2:0][15:0] raw);
    int cnt;
    cnt = (sample_cnt == 16'd0) ? 1 : int'(sample_cnt);
    for (int i = 0; i < 3; i++) cal_sum[s][i] += int'($signed(raw[i]));
    cal_seen[s] = cal_seen[s] + 16'd1;
    if (cal_seen[s] != 16'd0 && int'(cal_seen[s]) < cnt) return 1'b0;
    for (int i = 0; i < 3; i++) begin
      cal_off[s][i] = 16'(cal_sum[s][i] / cnt);
      cal_sum[s][i] = 0;
    end
    cal_seen[s] = '0;
    return 1'b1;
  endfunction

  function automatic imu_result_t correct_frame(imu_frame_t f);
    imu_result_t r;
    logic [15:0] v;
    r.smp  = f.smp;
    r.done = 1'b0;
    if (f.op == OP_NORMAL) begin
      // accel z is never corrected
      for (int i = 0; i < 2; i++) r.smp[i] = f.smp[i] - cal_off[SENS_ACC][i];
      for (int i = 0; i < 3; i++) begin
        v = f.smp[3 + i] - cal_off[SENS_GYRO][i];
        if ($signed(v) > -gyro_db && $signed(v) < gyro_db) v = '0;
        r.smp[3 + i] = v;
      end
    end else if (f.op == OP_GYRO_CAL) begin
      r.done = accumulate_cal(SENS_GYRO, f.smp[5:3]);
    end else if (f.op == OP_ACC_CAL) begin
      r.done = accumulate_cal(SENS_ACC, f.smp[2:0]);
    end
    return r;
  endfunction

  task automatic idle_input(int cycles);
    @(negedge clk);
    in_tvalid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SAMPLE_COUNT) begin
      sample_cnt = val;
    end else begin
      gyro_db = int'(val[14:0]);
    end
  endtask

  // Drain the block, then write; no frame may be in flight.
  task automatic settle_and_write(logic idx, logic [15:0] val);
    idle_input(1);
    wait (frames_out == frames_in);
    write_reg(idx, val);
  endtask

  task automatic send_frame(imu_frame_t f, bit typed, imu_result_t want);
    imu_result_t pred;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= f.op;
    in_tdata  <= f.smp;
    do @(posedge clk); while (!in_tready);
    // advance the predictor on every transaction, typed rows included
    pred = correct_frame(f);
    results_due.push_back(typed ? want : pred);
    frames_in++;
  endtask

  task automatic pace_input();
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) idle_input($urandom_range(1, 40));
    end
  endtask

  // receiver: random stall patterns, plus long hold-offs on request
  always @(negedge clk) begin : rx_pattern
    int mode;
    int mode_left;
    int rx_cycle;
    if (hold_served != hold_req) begin
      out_tready <= 1'b0;
      repeat (LONG_HOLD) @(negedge clk);
      hold_served++;
    end else begin
      if (mode_left <= 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(10, 150);
      end
      mode_left--;
      rx_cycle++;
      case (mode)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        2: out_tready <= ($urandom_range(0, 3) == 0);
        default: out_tready <= ((rx_cycle % 7) < 3);
      endcase
    end
  end

  always @(posedge clk) begin : check_results
    imu_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (results_due.size() == 0) begin
        $error("result with no frame outstanding: tdata %h tuser %b", out_tdata, out_tuser);
        mismatches++;
      end else begin
        want = results_due.pop_front();
        for (int i = 0; i < 6; i++) begin
          if (out_tdata[16*i +: 16] !== want.smp[i]) begin
            $error("%s: expected %0d, got %0d", lane_label[i], $signed(want.smp[i]),
                   $signed(out_tdata[16*i +: 16]));
            mismatches++;
          end
        end
        if (out_tuser !== want.done) begin
          $error("calibration_done: expected %0d, got %0d", want.done, out_tuser);
          mismatches++;
        end
      end
      frames_out++;
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we || !rst_n) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $error("no transaction for %0d cycles", WATCHDOG_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    dir_row_t    row;
    imu_frame_t  f;
    imu_result_t w;
    logic [15:0] bias [6];
    logic [15:0] val;
    int          phase;
    int          r;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int k = 0; k < $size(DIR_TAB); k++) begin
      row = DIR_TAB[k];
      if (row.kind == ROW_CFG) begin
        settle_and_write(1'(row.op), 16'(row.ax));
      end else begin
        f.op  = 2'(row.op);
        f.smp = {16'(row.gz), 16'(row.gy), 16'(row.gx), 16'(row.az), 16'(row.ay),
                 16'(row.ax)};
        w.done = 1'(row.wdone);
        w.smp  = {16'(row.wgz), 16'(row.wgy), 16'(row.wgx), 16'(row.waz), 16'(row.way),
                  16'(row.wax)};
        send_frame(f, row.kind == ROW_CHECKED, w);
        pace_input();
      end
    end

    phase = 0;
    while (frames_in < TOTAL_FRAMES) begin
      r = $urandom_range(0, 19);
      if (r == 0) begin
        val = 16'd0;
      end else if (r == 1) begin
        val = 16'd65535;
      end else if (r == 2) begin
        val = 16'($urandom_range(1, 65535));
      end else begin
        val = 16'($urandom_range(1, 8));
      end
      settle_and_write(CFG_SAMPLE_COUNT, val);

      r = $urandom_range(0, 7);
      if (r == 0) begin
        val = 16'd0;
      end else if (r == 1) begin
        val = 16'd32767;
      end else if (r == 2) begin
        val = 16'($urandom_range(0, 32767));
      end else begin
        val = 16'($urandom_range(0, 24));
      end
      // bit 15 lies outside the deadband register
      val[15] = 1'($urandom_range(0, 1));
      write_reg(CFG_GYRO_DEADBAND, val);

      phase++;
      if (phase == 2 || phase == 9) hold_req++;

      for (int i = 0; i < 6; i++) bias[i] = 16'($urandom);
      repeat ($urandom_range(20, 50)) begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          f.op = OP_NORMAL;
        end else if (r < 70) begin
          f.op = OP_GYRO_CAL;
        end else if (r < 95) begin
          f.op = OP_ACC_CAL;
        end else begin
          f.op = OP_RSVD;
        end
        // mostly samples near a fixed bias, so offsets and deadband come into play
        for (int i = 0; i < 6; i++) begin
          if ($urandom_range(0, 9) < 7) begin
            f.smp[i] = 16'(bias[i] + $urandom_range(0, 48) - 24);
          end else begin
            f.smp[i] = 16'($urandom);
          end
        end
        send_frame(f, 1'b0, '0);
        pace_input();
      end
    end

    idle_input(1);
    wait (frames_out == frames_in);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (results_due.size() != 0) begin
      $error("%0d expected results never arrived", results_due.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
